### rtl/madf_pkg.sv
package madf_pkg;

    localparam int FUNC_W         = 3;
    localparam int MAC_W          = 48;
    localparam int STATUS_W       = 2;
    localparam int LIST_DEPTH_DEF = 16;

    // operation codes as carried on the input tuser
    typedef enum logic [FUNC_W-1:0] {
        OP_QUERY       = 3'd0,
        OP_ADD_DENY    = 3'd1,
        OP_ADD_ALLOW   = 3'd2,
        OP_CLEAR_DENY  = 3'd3,
        OP_CLEAR_ALLOW = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_SKIPPED = 2'd2
    } status_t;

    // one classified command in the queue between front and back
    typedef struct packed {
        op_t              op;
        logic [MAC_W-1:0] mac;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_RESOLVE
    } back_state_t;

endpackage

### rtl/madf_front.sv
module madf_front
    import madf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [FUNC_W-1:0] s_tuser,
    input  logic [MAC_W-1:0]  s_tdata,
    output logic              q_valid,
    output cmd_t              q_cmd,
    input  logic              q_pop
);

    localparam int Q_DEPTH = 2;

    cmd_t       q_mem_reg [Q_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] q_cnt_reg,  q_cnt_next;
    logic       push;
    op_t        in_op;

    // unused codes behave as a query
    always_comb begin
        unique case (s_tuser)
            OP_ADD_DENY, OP_ADD_ALLOW, OP_CLEAR_DENY, OP_CLEAR_ALLOW: in_op = op_t'(s_tuser);
            default: in_op = OP_QUERY;
        endcase
    end

    assign s_tready = (q_cnt_reg != 2'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (q_cnt_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= '{op: in_op, mac: s_tdata};
        end
    end

endmodule

### rtl/madf_back.sv
module madf_back
    import madf_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  cmd_t                q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    back_state_t state_reg, state_next;

    cmd_t                  cmd_reg;
    logic [MAC_W-1:0]      deny_tab_reg  [LIST_DEPTH];
    logic [MAC_W-1:0]      allow_tab_reg [LIST_DEPTH];
    logic [CNT_W-1:0]      deny_cnt_reg,  deny_cnt_next;
    logic [CNT_W-1:0]      allow_cnt_reg, allow_cnt_next;
    logic [LIST_DEPTH-1:0] deny_hit_reg,  deny_hit_next;
    logic [LIST_DEPTH-1:0] allow_hit_reg, allow_hit_next;

    logic    out_valid_reg, out_valid_next;
    logic    allowed_reg, denied_reg;
    status_t status_reg;

    logic    load_cmd, capture_hit, resolve_fire, out_free;
    logic    in_deny, in_allow, allowed;
    logic    deny_full, allow_full;
    logic    deny_wr, allow_wr;
    status_t status;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:    if (q_valid)  state_next = BK_MATCH;
            BK_MATCH:   state_next = BK_RESOLVE;
            BK_RESOLVE: if (out_free) state_next = BK_IDLE;
            default:    state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        load_cmd     = (state_reg == BK_IDLE) && q_valid;
        capture_hit  = (state_reg == BK_MATCH);
        resolve_fire = (state_reg == BK_RESOLVE) && out_free;
    end

    assign q_pop = load_cmd;

    // parallel compare against the valid part of each list
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cmp
        assign deny_hit_next[i]  = (CNT_W'(i) < deny_cnt_reg)
                                   && (deny_tab_reg[i] == cmd_reg.mac);
        assign allow_hit_next[i] = (CNT_W'(i) < allow_cnt_reg)
                                   && (allow_tab_reg[i] == cmd_reg.mac);
    end

    always_comb begin
        in_deny    = |deny_hit_reg;
        in_allow   = |allow_hit_reg;
        allowed    = (allow_cnt_reg == '0) ? !in_deny : in_allow;
        deny_full  = (deny_cnt_reg  >= CNT_W'(LIST_DEPTH));
        allow_full = (allow_cnt_reg >= CNT_W'(LIST_DEPTH));
        status     = ST_DONE;
        deny_wr    = 1'b0;
        allow_wr   = 1'b0;
        deny_cnt_next  = deny_cnt_reg;
        allow_cnt_next = allow_cnt_reg;
        unique case (cmd_reg.op)
            OP_ADD_DENY: begin
                if (!allowed) begin
                    status = ST_SKIPPED;
                end else if (deny_full) begin
                    status = ST_FULL;
                end else begin
                    deny_wr       = resolve_fire;
                    deny_cnt_next = deny_cnt_reg + CNT_W'(1);
                end
            end
            OP_ADD_ALLOW: begin
                if (allow_full) begin
                    status = ST_FULL;
                end else begin
                    allow_wr       = resolve_fire;
                    allow_cnt_next = allow_cnt_reg + CNT_W'(1);
                end
            end
            OP_CLEAR_DENY:  deny_cnt_next  = '0;
            OP_CLEAR_ALLOW: allow_cnt_next = '0;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (resolve_fire) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            deny_cnt_reg  <= '0;
            allow_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (resolve_fire) begin
                deny_cnt_reg  <= deny_cnt_next;
                allow_cnt_reg <= allow_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_cmd) begin
            cmd_reg <= q_cmd;
        end
        if (capture_hit) begin
            deny_hit_reg  <= deny_hit_next;
            allow_hit_reg <= allow_hit_next;
        end
        if (resolve_fire) begin
            allowed_reg <= allowed;
            denied_reg  <= in_deny;
            status_reg  <= status;
        end
        if (deny_wr) begin
            deny_tab_reg[deny_cnt_reg[IDX_W-1:0]] <= cmd_reg.mac;
        end
        if (allow_wr) begin
            allow_tab_reg[allow_cnt_reg[IDX_W-1:0]] <= cmd_reg.mac;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, status_reg, denied_reg, allowed_reg};

endmodule

### rtl/mac_allow_deny_filter_unit.sv
// an accepted word passes the queue, the command register, the hit registers and the output
// register; the back end's fetch, compare and resolve steps end before it takes a new command
// the 2-word command queue accepts while the back end or master side stalls, until it is full
// reset: synchronous, active low; empties the queue and the output register and
// sets both list counts to zero, table contents are left as they are
module mac_allow_deny_filter_unit
    import madf_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF   // entries in each of the two lists
) (
    input  logic              aclk,
    input  logic              aresetn,
    // slave side: one command word per handshake
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [FUNC_W-1:0] s_tuser,          // [2:0] func
    input  logic [MAC_W-1:0]  s_tdata,          // [47:0] mac
    // master side: one result word per command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata           // [0] allowed, [1] denied_match, [3:2] status
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // front: decodes func and buffers the command
    madf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    // back: looks the mac up in both lists, applies the operation, holds the result
    madf_back #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/madf_checker.sv
module madf_checker
    import madf_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // out of reset the queue is empty and no result is pending
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("queue or output not empty after reset");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:2] == ST_DONE || m_tdata[3:2] == ST_FULL
                      || m_tdata[3:2] == ST_SKIPPED) && m_tdata[7:4] == 4'b0000)
        else $error("bad status code or padding");

    // a skipped deny add only happens for a mac that is not allowed
    a_skip_not_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:2] == ST_SKIPPED |-> !m_tdata[0])
        else $error("deny add skipped for an allowed mac");

endmodule

bind mac_allow_deny_filter_unit madf_checker u_madf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/tb_mac_allow_deny_filter_unit.sv
module tb_mac_allow_deny_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import madf_pkg::*;

    // one command word as it goes onto the slave side
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MAC_W-1:0]  mac;
    } cmd_word_t;

    // what the filter should answer for one command
    typedef struct packed {
        status_t status;
        logic    denied;
        logic    allowed;
    } verdict_t;

    // operation mix of one random segment
    typedef enum int {
        MIX_DENY,   // allow list emptied first, mostly deny adds and lookups
        MIX_ALLOW,  // allow list in use, deny adds only pass for listed addresses
        MIX_EVEN,   // every operation with a fair share
        MIX_NOISE   // any func code, any address
    } mix_t;

    localparam int                DEPTH            = LIST_DEPTH_DEF;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = FUNC_W'(OP_CLEAR_ALLOW + 1);
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = '1;
    localparam logic [MAC_W-1:0]  MAC_ZERO         = '0;
    localparam logic [MAC_W-1:0]  MAC_ONES         = '1;
    localparam int                POOL_SIZE        = 8;
    localparam int                RANDOM_WORDS     = 950;
    localparam int                HOLD_START       = 1200;
    localparam int                HOLD_CYCLES      = 200;
    localparam int                WATCHDOG_LIMIT   = 2000;
    localparam int                DRAIN_CYCLES     = 12;
    localparam int                MAX_SHOWN        = 10;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [FUNC_W-1:0] s_tuser  = '0;
    logic [MAC_W-1:0]  s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;

    // stimulus and expectations
    cmd_word_t         pending_words [$];
    verdict_t          verdict_q [$];
    cmd_word_t         next_word;
    verdict_t          want;
    logic [MAC_W-1:0]  mac_pool [POOL_SIZE];

    // shadow copy of the two address lists
    logic [MAC_W-1:0]  deny_list  [DEPTH];
    logic [MAC_W-1:0]  allow_list [DEPTH];
    int                deny_used  = 0;
    int                allow_used = 0;

    // handshake pacing and bookkeeping
    int                send_gap    = 0;
    bit                send_burst  = 1'b0;
    int                recv_stall  = 0;
    bit                recv_burst  = 1'b0;
    logic              recv_hold   = 1'b0;
    int                run_cycles  = 0;
    int                idle_cycles = 0;
    int                words_in    = 0;
    int                words_out   = 0;
    int                mismatches  = 0;
    int                total_words = 0;

    mac_allow_deny_filter_unit #(
        .LIST_DEPTH (DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),    // [2:0] func
        .s_tdata  (s_tdata),    // [47:0] mac
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [0] allowed, [1] denied_match, [3:2] status
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // looks the address up in both lists, then applies the operation to the shadow lists
    function automatic verdict_t screen_mac(input logic [FUNC_W-1:0] func,
                                            input logic [MAC_W-1:0]  mac);
        verdict_t v;
        bit       in_deny  = 1'b0;
        bit       in_allow = 1'b0;
        for (int i = 0; i < deny_used; i++)
            if (deny_list[i] == mac) in_deny = 1'b1;
        for (int i = 0; i < allow_used; i++)
            if (allow_list[i] == mac) in_allow = 1'b1;
        // an empty allow list falls back to the deny list
        v.allowed = (allow_used == 0) ? !in_deny : in_allow;
        v.denied  = in_deny;
        v.status  = ST_DONE;
        case (func)
            OP_ADD_DENY: begin
                // the allowed check wins over a full table
                if (!v.allowed) begin
                    v.status = ST_SKIPPED;
                end else if (deny_used >= DEPTH) begin
                    v.status = ST_FULL;
                end else begin
                    deny_list[deny_used] = mac;
                    deny_used++;
                end
            end
            OP_ADD_ALLOW: begin
                // duplicates take a slot of their own
                if (allow_used >= DEPTH) begin
                    v.status = ST_FULL;
                end else begin
                    allow_list[allow_used] = mac;
                    allow_used++;
                end
            end
            OP_CLEAR_DENY:  deny_used  = 0;
            OP_CLEAR_ALLOW: allow_used = 0;
            default: ;  // query and the spare codes leave the lists alone
        endcase
        return v;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] r = {$urandom(), $urandom()};
        return r[MAC_W-1:0];
    endfunction

    // mostly addresses from a small pool so lookups hit, some one bit off, some fresh
    function automatic logic [MAC_W-1:0] pick_mac();
        int               roll = $urandom_range(0, 99);
        logic [MAC_W-1:0] m    = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 15)
            m[$urandom_range(0, MAC_W - 1)] ^= 1'b1;
        else if (roll < 35)
            m = rand_mac();
        else if (roll < 39)
            m = roll[0] ? MAC_ONES : MAC_ZERO;
        return m;
    endfunction

    function automatic logic [FUNC_W-1:0] draw_func(input mix_t mix);
        int                roll  = $urandom_range(0, 99);
        logic [FUNC_W-1:0] spare = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        case (mix)
            MIX_DENY: begin
                if (roll < 45)      return OP_QUERY;
                else if (roll < 93) return OP_ADD_DENY;
                else if (roll < 95) return OP_CLEAR_DENY;
                else if (roll < 98) return spare;
                else                return OP_CLEAR_ALLOW;
            end
            MIX_ALLOW: begin
                if (roll < 35)      return OP_QUERY;
                else if (roll < 60) return OP_ADD_ALLOW;
                else if (roll < 86) return OP_ADD_DENY;
                else if (roll < 90) return OP_CLEAR_DENY;
                else if (roll < 94) return OP_CLEAR_ALLOW;
                else                return spare;
            end
            MIX_EVEN: begin
                if (roll < 40)      return OP_QUERY;
                else if (roll < 60) return OP_ADD_DENY;
                else if (roll < 78) return OP_ADD_ALLOW;
                else if (roll < 86) return OP_CLEAR_DENY;
                else if (roll < 94) return OP_CLEAR_ALLOW;
                else                return spare;
            end
            default: return FUNC_W'($urandom_range(0, FUNC_SPARE_LAST));
        endcase
    endfunction

    function automatic void queue_word(input logic [FUNC_W-1:0] func,
                                       input logic [MAC_W-1:0]  mac);
        cmd_word_t w;
        w.func = func;
        w.mac  = mac;
        pending_words.insert(pending_words.size(), w);
    endfunction

    // stimulus, reset and end of run
    initial begin
        mix_t             mix;
        int               seg_len;
        int               made;
        logic [FUNC_W-1:0] f;
        logic [MAC_W-1:0]  m;

        foreach (mac_pool[i]) mac_pool[i] = rand_mac();

        // directed: empty lists, spare codes, deny rule, allow rule, clears
        queue_word(OP_QUERY,         MAC_ZERO);
        queue_word(OP_QUERY,         MAC_ONES);
        queue_word(FUNC_SPARE_FIRST, MAC_ZERO);
        queue_word(FUNC_SPARE_LAST,  MAC_ONES);
        queue_word(OP_ADD_DENY,      MAC_ZERO);
        queue_word(OP_ADD_DENY,      MAC_ZERO);     // now denied, add is skipped
        queue_word(OP_QUERY,         MAC_ZERO);
        queue_word(OP_ADD_ALLOW,     MAC_ONES);
        queue_word(OP_ADD_ALLOW,     MAC_ONES);     // duplicate takes a second slot
        queue_word(OP_QUERY,         MAC_ONES);
        queue_word(OP_QUERY,         MAC_ZERO);     // allow list in use, not on it
        queue_word(OP_ADD_DENY,      MAC_ONES);     // allowed by the allow list
        queue_word(OP_ADD_DENY,      mac_pool[0]);  // not allowed, skipped
        queue_word(FUNC_W'(FUNC_SPARE_FIRST + 1), MAC_ONES);
        queue_word(OP_CLEAR_DENY,    MAC_ONES);     // flags still see the old deny list
        queue_word(OP_QUERY,         MAC_ONES);
        queue_word(OP_CLEAR_ALLOW,   MAC_ONES);
        queue_word(OP_QUERY,         MAC_ZERO);
        queue_word(OP_CLEAR_DENY,    MAC_ZERO);     // clear of an empty list

        // random segments, each with its own operation mix
        made = 0;
        while (made < RANDOM_WORDS) begin
            mix     = mix_t'($urandom_range(MIX_DENY, MIX_NOISE));
            seg_len = $urandom_range(30, 60);
            for (int k = 0; k < 3; k++)
                mac_pool[$urandom_range(0, POOL_SIZE - 1)] = rand_mac();
            if (mix == MIX_DENY) begin
                queue_word(OP_CLEAR_ALLOW, pick_mac());
                made++;
            end
            for (int j = 0; j < seg_len && made < RANDOM_WORDS; j++) begin
                f = draw_func(mix);
                if (mix == MIX_NOISE)
                    m = rand_mac();
                else if (f == OP_ADD_DENY && $urandom_range(0, 1) == 1)
                    m = rand_mac();     // fresh addresses let the deny list fill up
                else
                    m = pick_mac();
                queue_word(f, m);
                made++;
            end
        end
        total_words = pending_words.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // sampled away from the active edge
        while (words_in < total_words || verdict_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // driver: predicts on every accepted word, then offers the next one after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                verdict_q.insert(verdict_q.size(), screen_mac(s_tuser, s_tdata));
                words_in++;
                if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 3);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_word.func;
                    s_tdata  <= next_word.mac;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result word with the oldest verdict, then stalls a while
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("result word %0d arrived with nothing pending: tdata %h",
                                 words_out, m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    // upper tdata bits are padding and must stay zero
                    if (m_tdata !== {4'b0000, want.status, want.denied, want.allowed}) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN) begin
                            $write("mismatch on result word %0d: allowed %0b/%0b, ",
                                   words_out, want.allowed, m_tdata[0]);
                            $display({"denied_match %0b/%0b, status %0d/%0d ",
                                      "(expected/actual), tdata %h"},
                                     want.denied, m_tdata[1], want.status, m_tdata[3:2],
                                     m_tdata);
                        end
                    end
                end
                words_out++;
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            m_tready <= (recv_stall == 0) && !recv_hold;
        end
    end

    // long receiver hold-off so the command queue fills and s_tready drops
    always @(posedge aclk) begin
        if (!aresetn) begin
            run_cycles <= 0;
            recv_hold  <= 1'b0;
        end else begin
            run_cycles <= run_cycles + 1;
            recv_hold  <= (run_cycles >= HOLD_START) && (run_cycles < HOLD_START + HOLD_CYCLES);
        end
    end

    // watchdog: too long without a handshake on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
